[hdl/nlosf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nlosf_pkg
// Shared types and constants of the gated median and smoothing range filter.
// ----------------------------------------------------------------------------
package nlosf_pkg;

    localparam int RANGE_W   = 20;
    localparam int POWER_W   = 12;
    localparam int FILT_W    = 28;
    localparam int COUNT_W   = 32;
    localparam int THR_W     = 10;
    localparam int GAIN_W    = 9;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NLOS     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NLOS_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = 8'd1;

    localparam logic [THR_W-1:0]  THR_RESET  = 10'd100;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd90;

    typedef struct packed {
        logic insert;  // shift a new sample in and reload the circulating ring
        logic step;    // compare and rotate the circulating ring one cell
    } t_cell_ctl;

endpackage
`default_nettype wire

[hdl/nlosf_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nlosf_cell
// One window cell: holds a sample, passes a circulating copy to its neighbor
// and counts how many stored samples rank below its own.
// ----------------------------------------------------------------------------
module nlosf_cell #(
    parameter int IDX_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire nlosf_pkg::t_cell_ctl          i_ctl,
    input  wire signed [nlosf_pkg::RANGE_W-1:0] i_shin_val,
    input  wire                                i_shin_occ,
    input  wire signed [nlosf_pkg::RANGE_W-1:0] i_circ_val,
    input  wire                                i_circ_occ,
    input  wire        [IDX_W-1:0]             i_circ_idx,
    input  wire        [IDX_W-1:0]             i_lo_rank,
    input  wire        [IDX_W-1:0]             i_hi_rank,
    output logic signed [nlosf_pkg::RANGE_W-1:0] o_val,
    output logic                               o_occ,
    output logic signed [nlosf_pkg::RANGE_W-1:0] o_circ_val,
    output logic                               o_circ_occ,
    output logic       [IDX_W-1:0]             o_circ_idx,
    output logic                               o_is_lo,
    output logic                               o_is_hi
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic signed [nlosf_pkg::RANGE_W-1:0] r_val;
    logic                                 r_occ;
    logic signed [nlosf_pkg::RANGE_W-1:0] r_cval;
    logic                                 r_cocc;
    logic        [IDX_W-1:0]              r_cidx;
    logic        [IDX_W-1:0]              r_rank;
    logic                                 w_hit;

    // Ties break on cell position so every stored sample gets a distinct rank.
    assign w_hit = r_cocc && ((r_cval < r_val) || ((r_cval == r_val) && (r_cidx < MY_IDX)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= 1'b0;
            r_cocc <= 1'b0;
        end else if (i_ctl.insert) begin
            r_occ  <= i_shin_occ;
            r_cocc <= i_shin_occ;
        end else if (i_ctl.step) begin
            r_cocc <= i_circ_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_val  <= i_shin_val;
            r_cval <= i_shin_val;
            r_cidx <= MY_IDX;
            r_rank <= '0;
        end else if (i_ctl.step) begin
            r_cval <= i_circ_val;
            r_cidx <= i_circ_idx;
            r_rank <= r_rank + IDX_W'(w_hit);
        end
    end

    assign o_val      = r_val;
    assign o_occ      = r_occ;
    assign o_circ_val = r_cval;
    assign o_circ_occ = r_cocc;
    assign o_circ_idx = r_cidx;
    assign o_is_lo    = r_occ && (r_rank == i_lo_rank);
    assign o_is_hi    = r_occ && (r_rank == i_hi_rank);

endmodule
`default_nettype wire

[hdl/nlos_gated_median_ema_range_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nlos_gated_median_ema_range_filter
// Range filter: drop invalid words, reject NLOS words, median of a sample
// window, then exponential smoothing in Q8 millimetres.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word carrying a status (accepted,
// NLOS, invalid), the smoothed range in 1/256 mm, a ready flag and the two
// wrapping counters. The block works on one word at a time: invalid and NLOS
// words go from acceptance straight to the emit state; an accepted word runs
// the rank pass, then the pick, difference, multiply and update states (the
// first accepted word seeds the filter and skips multiply and update). In the
// rank pass the window is a row of WINDOW_DEPTH cells; a copy of every sample
// travels once around the ring, one cell per cycle, while each cell counts how
// many samples rank below its own. A following multiply stage and a saturating
// add finish the smoothing. o_stall stays high from acceptance until the
// result is loaded into the output register; a result waiting there does not
// block the next word. Configuration writes are always ready and must only
// happen while the block is idle.
// ----------------------------------------------------------------------------
module nlos_gated_median_ema_range_filter #(
    parameter int WINDOW_DEPTH = 5
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    // input words
    input  wire                                       i_valid,
    output logic                                      o_stall,
    input  wire signed [nlosf_pkg::RANGE_W-1:0]       i_range_mm,
    input  wire signed [nlosf_pkg::POWER_W-1:0]       i_total_power,
    input  wire signed [nlosf_pkg::POWER_W-1:0]       i_first_path_power,
    input  wire                                       i_measurement_ok,
    // result words
    output logic                                      o_valid,
    input  wire                                       i_stall,
    output logic       [nlosf_pkg::STATUS_W-1:0]      o_status,
    output logic signed [nlosf_pkg::FILT_W-1:0]       o_filtered_range,
    output logic                                      o_filter_ready,
    output logic       [nlosf_pkg::COUNT_W-1:0]       o_accepted_total,
    output logic       [nlosf_pkg::COUNT_W-1:0]       o_rejected_total,
    // configuration writes
    input  wire                                       i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire        [nlosf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire        [nlosf_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(WINDOW_DEPTH);

    localparam int RW = nlosf_pkg::RANGE_W;
    localparam int FW = nlosf_pkg::FILT_W;
    localparam int CW = nlosf_pkg::COUNT_W;
    localparam int DW = FW + 1;                      // median minus smoothed
    localparam int PW = DW + nlosf_pkg::GAIN_W + 1;  // gain times difference
    localparam int SW = PW + 1;                      // widened update sum

    localparam logic signed [SW-1:0] SAT_HI = SW'(134217727);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(134217728);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RANK = 3'd1;
    localparam logic [2:0] S_PICK = 3'd2;
    localparam logic [2:0] S_DIFF = 3'd3;
    localparam logic [2:0] S_MULT = 3'd4;
    localparam logic [2:0] S_UPDT = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [IDX_W-1:0]                 r_step;
    logic [CNT_W-1:0]                 r_fill;
    logic [nlosf_pkg::THR_W-1:0]      r_thr;
    logic [nlosf_pkg::GAIN_W-1:0]     r_gain;
    logic [nlosf_pkg::STATUS_W-1:0]   r_status;
    logic                             r_seeded;
    logic signed [FW-1:0]             r_smoothed;
    logic [nlosf_pkg::COUNT_W-1:0]    r_acc_cnt;
    logic [nlosf_pkg::COUNT_W-1:0]    r_rej_cnt;
    logic signed [RW-1:0]             r_lo;
    logic signed [RW-1:0]             r_hi;
    logic signed [DW-1:0]             r_diff;
    logic signed [PW-1:0]             r_prod;

    logic                             r_out_valid;
    logic [nlosf_pkg::STATUS_W-1:0]   r_out_status;
    logic signed [FW-1:0]             r_out_filt;
    logic                             r_out_ready;
    logic [nlosf_pkg::COUNT_W-1:0]    r_out_acc;
    logic [nlosf_pkg::COUNT_W-1:0]    r_out_rej;

    logic                             w_in_acc;
    logic                             w_out_free;
    logic signed [nlosf_pkg::POWER_W:0] w_pdiff;
    logic                             w_nlos;
    logic                             w_good;
    nlosf_pkg::t_cell_ctl             w_ctl;
    logic [CNT_W-1:0]                 w_fill_m1;
    logic [IDX_W-1:0]                 w_lo_rank;
    logic [IDX_W-1:0]                 w_hi_rank;
    logic signed [RW-1:0]             w_lo_sel;
    logic signed [RW-1:0]             w_hi_sel;
    logic signed [RW:0]               w_mid_sum;
    logic signed [FW-1:0]             w_med_q8;
    logic signed [PW-1:0]             w_prod_fl;
    logic signed [SW-1:0]             w_upd;

    logic signed [RW-1:0]             w_val    [WINDOW_DEPTH];
    logic                             w_occ    [WINDOW_DEPTH];
    logic signed [RW-1:0]             w_cval   [WINDOW_DEPTH];
    logic                             w_cocc   [WINDOW_DEPTH];
    logic [IDX_W-1:0]                 w_cidx   [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]          w_is_lo;
    logic [WINDOW_DEPTH-1:0]          w_is_hi;

    // ---------------------------------------------------------------- handshake
    assign o_stall     = (r_state != S_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    // NLOS gate: exact 13-bit power difference against the unsigned threshold.
    assign w_pdiff = {i_total_power[nlosf_pkg::POWER_W-1], i_total_power}
                   - {i_first_path_power[nlosf_pkg::POWER_W-1], i_first_path_power};
    assign w_nlos  = $signed({w_pdiff[nlosf_pkg::POWER_W], w_pdiff})
                   > $signed({4'b0000, r_thr});
    assign w_good  = i_measurement_ok && !w_nlos;

    assign w_ctl.insert = w_in_acc && w_good;
    assign w_ctl.step   = (r_state == S_RANK);

    // ---------------------------------------------------------------- window row
    // Odd fill: both targets name the middle sample. Even fill: the two middles.
    assign w_fill_m1 = r_fill - CNT_W'(1);
    assign w_lo_rank = IDX_W'(w_fill_m1 >> 1);
    assign w_hi_rank = IDX_W'(r_fill >> 1);

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? WINDOW_DEPTH - 1 : g - 1;
        logic signed [RW-1:0] w_sh_val;
        logic                 w_sh_occ;

        if (g == 0) begin : g_head
            assign w_sh_val = i_range_mm;
            assign w_sh_occ = 1'b1;
        end else begin : g_body
            assign w_sh_val = w_val[g-1];
            assign w_sh_occ = w_occ[g-1];
        end

        nlosf_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_shin_val (w_sh_val),
            .i_shin_occ (w_sh_occ),
            .i_circ_val (w_cval[PREV]),
            .i_circ_occ (w_cocc[PREV]),
            .i_circ_idx (w_cidx[PREV]),
            .i_lo_rank  (w_lo_rank),
            .i_hi_rank  (w_hi_rank),
            .o_val      (w_val[g]),
            .o_occ      (w_occ[g]),
            .o_circ_val (w_cval[g]),
            .o_circ_occ (w_cocc[g]),
            .o_circ_idx (w_cidx[g]),
            .o_is_lo    (w_is_lo[g]),
            .o_is_hi    (w_is_hi[g])
        );
    end

    // Ranks are unique among stored samples, so an OR of the flagged cells picks one.
    always_comb begin
        w_lo_sel = '0;
        w_hi_sel = '0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            if (w_is_lo[k]) begin
                w_lo_sel = w_lo_sel | w_val[k];
            end
            if (w_is_hi[k]) begin
                w_hi_sel = w_hi_sel | w_val[k];
            end
        end
    end

    // ---------------------------------------------------------------- smoothing
    // Median in Q8 is (lo + hi) * 128, exact for odd and even fill alike.
    assign w_mid_sum = {r_lo[RW-1], r_lo} + {r_hi[RW-1], r_hi};
    assign w_med_q8  = {w_mid_sum, 7'b0000000};
    // Arithmetic shift floors toward minus infinity.
    assign w_prod_fl = r_prod >>> 8;
    assign w_upd     = {{(SW-FW){r_smoothed[FW-1]}}, r_smoothed}
                     + {w_prod_fl[PW-1], w_prod_fl};

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_good ? S_RANK : S_EMIT;
                end
            end
            S_RANK: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: n_state = S_DIFF;
            S_DIFF: n_state = r_seeded ? S_MULT : S_EMIT;
            S_MULT: n_state = S_UPDT;
            S_UPDT: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_fill    <= '0;
            r_thr     <= nlosf_pkg::THR_RESET;
            r_gain    <= nlosf_pkg::GAIN_RESET;
            r_seeded  <= 1'b0;
            r_smoothed <= '0;
            r_acc_cnt <= '0;
            r_rej_cnt <= '0;
        end else begin
            r_state <= n_state;

            // configuration: unknown indexes drop, data masks to register width
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    nlosf_pkg::REG_NLOS_THRESHOLD:
                        r_thr  <= i_cfg_data[nlosf_pkg::THR_W-1:0];
                    nlosf_pkg::REG_SMOOTHING_GAIN:
                        r_gain <= i_cfg_data[nlosf_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (w_in_acc && i_measurement_ok) begin
                if (w_nlos) begin
                    r_rej_cnt <= r_rej_cnt + CW'(1);
                end else begin
                    r_acc_cnt <= r_acc_cnt + CW'(1);
                    if (r_fill != FILL_FULL) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                end
            end

            // advance the rank pass one cell per cycle
            if (w_ctl.insert) begin
                r_step <= '0;
            end else if (r_state == S_RANK) begin
                r_step <= r_step + IDX_W'(1);
            end

            if (r_state == S_DIFF && !r_seeded) begin
                r_smoothed <= w_med_q8;
                r_seeded   <= 1'b1;
            end else if (r_state == S_UPDT) begin
                if (w_upd > SAT_HI) begin
                    r_smoothed <= SAT_HI[FW-1:0];
                end else if (w_upd < SAT_LO) begin
                    r_smoothed <= SAT_LO[FW-1:0];
                end else begin
                    r_smoothed <= w_upd[FW-1:0];
                end
            end
        end
    end

    // datapath registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status <= !i_measurement_ok ? nlosf_pkg::ST_INVALID
                      : (w_nlos ? nlosf_pkg::ST_NLOS : nlosf_pkg::ST_ACCEPTED);
        end
        if (r_state == S_PICK) begin
            r_lo <= w_lo_sel;
            r_hi <= w_hi_sel;
        end
        if (r_state == S_DIFF) begin
            r_diff <= {w_med_q8[FW-1], w_med_q8} - {r_smoothed[FW-1], r_smoothed};
        end
        if (r_state == S_MULT) begin
            r_prod <= PW'($signed({1'b0, r_gain})) * PW'(r_diff);
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_out_status <= r_status;
            r_out_filt   <= r_smoothed;
            r_out_ready  <= r_seeded;
            r_out_acc    <= r_acc_cnt;
            r_out_rej    <= r_rej_cnt;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_filtered_range = r_out_filt;
    assign o_filter_ready   = r_out_ready;
    assign o_accepted_total = r_out_acc;
    assign o_rejected_total = r_out_rej;

endmodule
`default_nettype wire

[hdl/nlosf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nlosf_checker
// Port-level checks of the range filter, bound to the top level.
// ----------------------------------------------------------------------------
module nlosf_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_valid,
    input wire                                  o_stall,
    input wire                                  o_valid,
    input wire                                  i_stall,
    input wire [nlosf_pkg::STATUS_W-1:0]        o_status,
    input wire signed [nlosf_pkg::FILT_W-1:0]   o_filtered_range,
    input wire                                  o_filter_ready,
    input wire [nlosf_pkg::COUNT_W-1:0]         o_accepted_total
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered_range) && $stable(o_status))
        else $error("stalled result word changed");

    // one word at a time: acceptance closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after acceptance");

    // an accepted sample always seeds the filter
    a_accept_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == nlosf_pkg::ST_ACCEPTED) |-> o_filter_ready)
        else $error("accepted word without filter ready");

    // without any accepted sample the filter reads zero
    a_unseeded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_filter_ready |-> (o_filtered_range == '0) && (o_accepted_total == '0))
        else $error("unseeded filter shows nonzero value");

    // status code three is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == nlosf_pkg::ST_ACCEPTED) || (o_status == nlosf_pkg::ST_NLOS)
                 || (o_status == nlosf_pkg::ST_INVALID))
        else $error("undefined status code");

endmodule

bind nlos_gated_median_ema_range_filter nlosf_checker u_nlosf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_status         (o_status),
    .o_filtered_range (o_filtered_range),
    .o_filter_ready   (o_filter_ready),
    .o_accepted_total (o_accepted_total)
);
`default_nettype wire
